// ===== rtl/positional_list_buffer_assert.svh =====
// Assertion macros for the positional list buffer RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef POSITIONAL_LIST_BUFFER_ASSERT_SVH
`define POSITIONAL_LIST_BUFFER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PLB_ASSERT_CLK(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
`define PLB_ASSERT(lbl, prop, msg) `PLB_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`else
`define PLB_ASSERT_CLK(lbl, clk_s, rst_s, prop, msg)
`define PLB_ASSERT(lbl, prop, msg)
`endif
`endif

// ===== rtl/plb_pkg.sv =====
// Shared types and constants for the positional list buffer.
// No dependencies; imported by plb_store and positional_list_buffer.
`default_nettype none

package plb_pkg;

    localparam int DATA_W      = 32;
    localparam int OP_W        = 3;
    localparam int POS_W       = 6;
    localparam int COUNT_W     = 6;
    localparam int MAX_RESULTS = 32;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_BACK  = 3'd4,
        OP_DEL_AT    = 3'd5,
        OP_DUMP      = 3'd6
    } plb_op_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_INVALID = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_EMPTY   = 2'd3
    } plb_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_PUT,
        ST_RESP,
        ST_DUMP_RD,
        ST_DUMP_OUT
    } plb_state_t;

    // memory port strobes from the sequencer
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } plb_mem_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/plb_store.sv =====
// Element store: one write port, one read port with registered read data.
// Depends on plb_pkg for the port strobe struct.
`default_nettype none

module plb_store
    import plb_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
)
(
    input  wire logic                     clk,
    input  wire plb_mem_ctl_t             ctl,
    input  wire logic [AW-1:0]            waddr,
    input  wire logic signed [DATA_W-1:0] wdata,
    input  wire logic [AW-1:0]            raddr,
    output logic signed [DATA_W-1:0]      rdata
);

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/positional_list_buffer.sv =====
// Positional list buffer top level: command decode, shift sequencer, result register.
// Depends on plb_pkg, plb_store and positional_list_buffer_assert.svh.
//
// Bounded ordered list of signed 32-bit values kept packed in a single-port-write,
// single-port-read RAM. One command is taken at a time; cmd_stall stays high until the
// command's last result beat has been loaded into the result register. Errors, an empty
// dump and the unused opcode go straight to the result state. An insert first moves each
// element behind the point of change, then writes the new value; a delete moves each
// element behind the removed one. Each move is a RAM read followed by a RAM write
// through the one pointer step unit. A dump reads and then presents each element, at
// most 32 beats. A stalled result beat holds the sequencer until it is taken.
// The store needs no clearing after reset: only entries below the count are ever read.
`default_nettype none

`include "positional_list_buffer_assert.svh"

module positional_list_buffer
    import plb_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cmd_valid,
    output logic                          cmd_stall,
    input  wire logic [OP_W-1:0]          operation,
    input  wire logic signed [DATA_W-1:0] value,
    input  wire logic [POS_W-1:0]         position,
    output logic                          res_valid,
    input  wire logic                     res_stall,
    output logic [1:0]                    status,
    output logic signed [DATA_W-1:0]      element,
    output logic [COUNT_W-1:0]            count,
    output logic                          last
);

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int AW    = $clog2(CAPACITY);
    localparam int PW    = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam int XW    = CW + COUNT_W;
    localparam int LIMIT = (CAPACITY < MAX_RESULTS) ? CAPACITY : MAX_RESULTS;

    localparam logic [CW-1:0] CAP_C   = CW'(CAPACITY);
    localparam logic [CW-1:0] CNT_ONE = CW'(1);
    localparam logic [PW-1:0] PW_ONE  = PW'(1);
    localparam logic [PW-1:0] LIMIT_X = PW'(LIMIT);

    plb_state_t               state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [AW-1:0]            idx_reg, idx_next;
    logic [AW-1:0]            ptr_reg, ptr_next;
    logic                     dir_ins_reg, dir_ins_next;
    logic signed [DATA_W-1:0] value_reg, value_next;
    plb_status_t              status_reg, status_next;

    logic                     res_valid_reg, res_valid_next;
    plb_status_t              res_status_reg, res_status_next;
    logic signed [DATA_W-1:0] element_reg, element_next;
    logic [COUNT_W-1:0]       count_out_reg, count_out_next;
    logic                     last_reg, last_next;

    plb_mem_ctl_t             mem_ctl;
    logic [AW-1:0]            mem_waddr;
    logic signed [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]            mem_raddr;
    logic signed [DATA_W-1:0] mem_rdata;

    logic [PW-1:0]            pos_x, cnt_x, ptr_x, dump_n;
    logic [AW-1:0]            ptr_step;
    logic [XW-1:0]            cnt_wide;
    logic                     is_full, is_empty, out_free, dump_last;
    logic                     do_ins, do_del;
    logic [AW-1:0]            tgt_idx;
    logic [POS_W-1:0]         pos_m1;
    logic [CW-1:0]            cnt_m1;

    plb_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .ctl   (mem_ctl),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign pos_x    = {{(PW-POS_W){1'b0}}, position};
    assign cnt_x    = {{(PW-CW){1'b0}}, count_reg};
    assign ptr_x    = {{(PW-AW){1'b0}}, ptr_reg};
    assign cnt_wide = {{COUNT_W{1'b0}}, count_reg};
    assign is_full  = (count_reg == CAP_C);
    assign is_empty = (count_reg == '0);
    assign pos_m1   = position - POS_W'(1);
    assign cnt_m1   = count_reg - CNT_ONE;
    assign out_free = !res_valid_reg || !res_stall;

    // the one step unit: walks the pointer down for inserts, up for deletes and dumps
    assign ptr_step = dir_ins_reg ? (ptr_reg - AW'(1)) : (ptr_reg + AW'(1));

    assign dump_n    = (cnt_x < LIMIT_X) ? cnt_x : LIMIT_X;
    assign dump_last = ((ptr_x + PW_ONE) == dump_n);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        ptr_reg        <= ptr_next;
        dir_ins_reg    <= dir_ins_next;
        value_reg      <= value_next;
        status_reg     <= status_next;
        res_status_reg <= res_status_next;
        element_reg    <= element_next;
        count_out_reg  <= count_out_next;
        last_reg       <= last_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        ptr_next        = ptr_reg;
        dir_ins_next    = dir_ins_reg;
        value_next      = value_reg;
        status_next     = status_reg;
        res_status_next = res_status_reg;
        element_next    = element_reg;
        count_out_next  = count_out_reg;
        last_next       = last_reg;
        res_valid_next  = res_valid_reg && res_stall;
        mem_ctl         = '0;
        mem_waddr       = ptr_reg;
        mem_wdata       = mem_rdata;
        mem_raddr       = ptr_step;
        do_ins          = 1'b0;
        do_del          = 1'b0;
        tgt_idx         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    value_next  = value;
                    status_next = STAT_OK;
                    state_next  = ST_RESP;
                    case (plb_op_t'(operation))
                        OP_INS_FRONT:
                        begin
                            if (is_full)
                                status_next = STAT_FULL;
                            else
                                do_ins = 1'b1;
                        end
                        OP_INS_BACK:
                        begin
                            tgt_idx = AW'(count_reg);
                            if (is_full)
                                status_next = STAT_FULL;
                            else
                                do_ins = 1'b1;
                        end
                        OP_INS_AT:
                        begin
                            tgt_idx = AW'(pos_m1);
                            if (pos_x == '0 || pos_x > (cnt_x + PW_ONE))
                                status_next = STAT_INVALID;
                            else if (is_full)
                                status_next = STAT_FULL;
                            else
                                do_ins = 1'b1;
                        end
                        OP_DEL_FRONT:
                        begin
                            if (is_empty)
                                status_next = STAT_EMPTY;
                            else
                                do_del = 1'b1;
                        end
                        OP_DEL_BACK:
                        begin
                            tgt_idx = AW'(cnt_m1);
                            if (is_empty)
                                status_next = STAT_EMPTY;
                            else
                                do_del = 1'b1;
                        end
                        OP_DEL_AT:
                        begin
                            tgt_idx = AW'(pos_m1);
                            if (is_empty)
                                status_next = STAT_EMPTY;
                            else if (pos_x == '0 || pos_x > cnt_x)
                                status_next = STAT_INVALID;
                            else
                                do_del = 1'b1;
                        end
                        OP_DUMP:
                        begin
                            if (!is_empty)
                            begin
                                ptr_next     = '0;
                                dir_ins_next = 1'b0;
                                state_next   = ST_DUMP_RD;
                            end
                        end
                        default:
                        begin
                            status_next = STAT_OK;
                        end
                    endcase

                    idx_next = tgt_idx;
                    if (do_ins)
                    begin
                        dir_ins_next = 1'b1;
                        ptr_next     = AW'(count_reg);
                        state_next   = (AW'(count_reg) == tgt_idx) ? ST_PUT : ST_SHIFT_RD;
                    end
                    else if (do_del)
                    begin
                        dir_ins_next = 1'b0;
                        ptr_next     = tgt_idx;
                        // nothing behind the removed element: just drop the count
                        if (({{(PW-AW){1'b0}}, tgt_idx} + PW_ONE) >= cnt_x)
                        begin
                            count_next = cnt_m1;
                            state_next = ST_RESP;
                        end
                        else
                        begin
                            state_next = ST_SHIFT_RD;
                        end
                    end
                end
            end

            ST_SHIFT_RD:
            begin
                mem_ctl.rd_en = 1'b1;
                mem_raddr     = ptr_step;
                state_next    = ST_SHIFT_WR;
            end

            ST_SHIFT_WR:
            begin
                mem_ctl.wr_en = 1'b1;
                mem_waddr     = ptr_reg;
                mem_wdata     = mem_rdata;
                ptr_next      = ptr_step;
                if (dir_ins_reg)
                begin
                    state_next = (ptr_step == idx_reg) ? ST_PUT : ST_SHIFT_RD;
                end
                else if (({{(PW-AW){1'b0}}, ptr_step} + PW_ONE) >= cnt_x)
                begin
                    count_next = cnt_m1;
                    state_next = ST_RESP;
                end
                else
                begin
                    state_next = ST_SHIFT_RD;
                end
            end

            ST_PUT:
            begin
                mem_ctl.wr_en = 1'b1;
                mem_waddr     = idx_reg;
                mem_wdata     = value_reg;
                count_next    = count_reg + CNT_ONE;
                state_next    = ST_RESP;
            end

            ST_RESP:
            begin
                if (out_free)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = status_reg;
                    element_next    = '0;
                    count_out_next  = cnt_wide[COUNT_W-1:0];
                    last_next       = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            ST_DUMP_RD:
            begin
                mem_ctl.rd_en = 1'b1;
                mem_raddr     = ptr_reg;
                state_next    = ST_DUMP_OUT;
            end

            ST_DUMP_OUT:
            begin
                if (out_free)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = STAT_OK;
                    element_next    = mem_rdata;
                    count_out_next  = cnt_wide[COUNT_W-1:0];
                    last_next       = dump_last;
                    ptr_next        = ptr_step;
                    state_next      = dump_last ? ST_IDLE : ST_DUMP_RD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign cmd_stall = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign status    = res_status_reg;
    assign element   = element_reg;
    assign count     = count_out_reg;
    assign last      = last_reg;

    `PLB_ASSERT(a_count_bound, count_reg <= CAP_C, "element count above capacity")
    `PLB_ASSERT(a_count_on_resp,
                (count_reg != $past(count_reg)) |-> (state_reg == ST_RESP),
                "count moved outside a command finish")
    `PLB_ASSERT(a_count_step,
                (count_reg != $past(count_reg)) |->
                    ((count_reg == ($past(count_reg) + CNT_ONE)) ||
                     (count_reg == ($past(count_reg) - CNT_ONE))),
                "count moved by more than one")
    `PLB_ASSERT(a_dump_in_range, (state_reg == ST_DUMP_RD) |-> (ptr_x < cnt_x), "dump read beyond stored elements")

endmodule

`default_nettype wire
